@@ hdl/ioc_pkg.sv @@
package ioc_pkg;

	localparam int NAXES    = 6;
	localparam int AXIS_W   = 16;
	localparam int SUM_W    = 27;
	localparam int IDX_W    = 11;
	localparam int RANGE_W  = 2;
	localparam int SAT_IN_W = SUM_W + 2;

	// calibration run lengths
	localparam int DISCARD   = 101;
	localparam int AVG_COUNT = 1000;

	// axis order inside an axis vector
	localparam int AX_I = 0;
	localparam int AY_I = 1;
	localparam int AZ_I = 2;
	localparam int GX_I = 3;
	localparam int GY_I = 4;
	localparam int GZ_I = 5;

	localparam logic [AXIS_W-1:0] AXIS_MAX = {1'b0, {(AXIS_W-1){1'b1}}};
	localparam logic [AXIS_W-1:0] AXIS_MIN = {1'b1, {(AXIS_W-1){1'b0}}};
	// one g at the 2g range
	localparam logic [AXIS_W-1:0] ONE_G = AXIS_W'(16384);

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_START  = 2'd1,
		OP_LOAD   = 2'd2
	} op_t;

	typedef logic [NAXES-1:0][AXIS_W-1:0] axes_t;
	typedef logic [NAXES-1:0][SUM_W-1:0]  sums_t;

	typedef struct packed {
		op_t   op;
		axes_t axes;
	} item_t;

	typedef struct packed {
		axes_t corr;
		logic  calibrating;
		logic  calib_done;
	} result_t;

	// clamp a wide two's complement value to one axis word
	function automatic logic [AXIS_W-1:0] sat_axis(input logic [SAT_IN_W-1:0] v);
		logic [SAT_IN_W-AXIS_W:0] hi;
		hi = v[SAT_IN_W-1:AXIS_W-1];
		if (&hi || ~|hi) begin
			return v[AXIS_W-1:0];
		end else if (v[SAT_IN_W-1]) begin
			return AXIS_MIN;
		end else begin
			return AXIS_MAX;
		end
	endfunction

endpackage

@@ hdl/ioc_if.sv @@
interface ioc_smp_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          op;
	logic signed [ioc_pkg::AXIS_W-1:0]   accel_x;
	logic signed [ioc_pkg::AXIS_W-1:0]   accel_y;
	logic signed [ioc_pkg::AXIS_W-1:0]   accel_z;
	logic signed [ioc_pkg::AXIS_W-1:0]   gyro_x;
	logic signed [ioc_pkg::AXIS_W-1:0]   gyro_y;
	logic signed [ioc_pkg::AXIS_W-1:0]   gyro_z;

	modport source (output valid, op, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		input ready);
	modport sink (input valid, op, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
		output ready);
endinterface

interface ioc_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [ioc_pkg::AXIS_W-1:0]   corr_accel_x;
	logic signed [ioc_pkg::AXIS_W-1:0]   corr_accel_y;
	logic signed [ioc_pkg::AXIS_W-1:0]   corr_accel_z;
	logic signed [ioc_pkg::AXIS_W-1:0]   corr_gyro_x;
	logic signed [ioc_pkg::AXIS_W-1:0]   corr_gyro_y;
	logic signed [ioc_pkg::AXIS_W-1:0]   corr_gyro_z;
	logic                                calibrating;
	logic                                calib_done;

	modport source (output valid, corr_accel_x, corr_accel_y, corr_accel_z, corr_gyro_x,
		corr_gyro_y, corr_gyro_z, calibrating, calib_done, input ready);
	modport sink (input valid, corr_accel_x, corr_accel_y, corr_accel_z, corr_gyro_x,
		corr_gyro_y, corr_gyro_z, calibrating, calib_done, output ready);
endinterface

interface ioc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ioc_pkg::RANGE_W-1:0]     data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ hdl/ioc_mean_div.sv @@
module ioc_mean_div (
	input  logic                          clk,
	input  logic                          capture,
	input  ioc_pkg::sums_t                sums,
	input  logic [ioc_pkg::RANGE_W-1:0]   accel_range,
	output ioc_pkg::axes_t                bias_new
);

	// reciprocal multiply, exact for any magnitude of SUM_W bits
	localparam int K       = ioc_pkg::SUM_W + $clog2(ioc_pkg::AVG_COUNT);
	localparam int RECIP_W = ioc_pkg::SUM_W + 1;
	localparam int PROD_W  = ioc_pkg::SUM_W + RECIP_W;
	localparam int QUOT_W  = PROD_W - K;
	localparam longint unsigned RECIP_L =
		((64'd1 << K) + 64'(ioc_pkg::AVG_COUNT) - 64'd1) / 64'(ioc_pkg::AVG_COUNT);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

	logic [ioc_pkg::SUM_W-1:0]    mag  [ioc_pkg::NAXES];
	logic [PROD_W-1:0]            prod [ioc_pkg::NAXES];
	logic [QUOT_W-1:0]            quot_s1 [ioc_pkg::NAXES];
	logic [ioc_pkg::NAXES-1:0]    neg_s1;
	logic [ioc_pkg::SAT_IN_W-1:0] qs   [ioc_pkg::NAXES];
	logic [ioc_pkg::AXIS_W-1:0]   mean [ioc_pkg::NAXES];
	logic [ioc_pkg::AXIS_W-1:0]   one_g;

	always_comb begin
		for (int k = 0; k < ioc_pkg::NAXES; k++) begin
			mag[k]  = sums[k][ioc_pkg::SUM_W-1] ? -sums[k] : sums[k];
			prod[k] = PROD_W'(mag[k]) * PROD_W'(RECIP);
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			for (int k = 0; k < ioc_pkg::NAXES; k++) begin
				quot_s1[k] <= prod[k][PROD_W-1:K];
				neg_s1[k]  <= sums[k][ioc_pkg::SUM_W-1];
			end
		end
	end

	// restore sign (truncation toward zero), clamp, take one g off accel z
	always_comb begin
		one_g = ioc_pkg::ONE_G >> accel_range;
		for (int k = 0; k < ioc_pkg::NAXES; k++) begin
			qs[k]   = neg_s1[k] ? -ioc_pkg::SAT_IN_W'(quot_s1[k])
				: ioc_pkg::SAT_IN_W'(quot_s1[k]);
			mean[k] = ioc_pkg::sat_axis(qs[k]);
			bias_new[k] = mean[k];
		end
		bias_new[ioc_pkg::AZ_I] = ioc_pkg::sat_axis(
			ioc_pkg::SAT_IN_W'($signed(mean[ioc_pkg::AZ_I])) - ioc_pkg::SAT_IN_W'(one_g));
	end

endmodule

@@ hdl/ioc_calib_core.sv @@
module ioc_calib_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  ioc_pkg::item_t                item,
	input  logic [ioc_pkg::RANGE_W-1:0]   accel_range,
	output ioc_pkg::result_t              res,
	output logic                          busy
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MUL  = 3'b010,
		ST_FIN  = 3'b100
	} div_state_t;

	localparam logic [ioc_pkg::IDX_W-1:0] FIRST_SUM = ioc_pkg::IDX_W'(ioc_pkg::DISCARD);
	localparam logic [ioc_pkg::IDX_W-1:0] LAST_SUM  =
		ioc_pkg::IDX_W'(ioc_pkg::DISCARD + ioc_pkg::AVG_COUNT - 1);

	ioc_pkg::axes_t              bias_q;
	ioc_pkg::sums_t              sum_q;
	logic [ioc_pkg::IDX_W-1:0]   idx_q;
	logic                        active_q;
	div_state_t                  state_q;

	ioc_pkg::sums_t              sum_d;
	logic [ioc_pkg::IDX_W-1:0]   idx_d;
	logic                        active_d;
	logic                        done;
	ioc_pkg::axes_t              bias_new;

	always_comb begin
		res.corr = '0;
		sum_d    = sum_q;
		idx_d    = idx_q;
		active_d = active_q;
		done     = 1'b0;
		unique case (item.op)
			ioc_pkg::OP_SAMPLE: begin
				for (int k = 0; k < ioc_pkg::NAXES; k++) begin
					res.corr[k] = ioc_pkg::sat_axis(
						ioc_pkg::SAT_IN_W'($signed(item.axes[k]))
						- ioc_pkg::SAT_IN_W'($signed(bias_q[k])));
				end
				if (active_q) begin
					if (idx_q >= FIRST_SUM) begin
						for (int k = 0; k < ioc_pkg::NAXES; k++) begin
							sum_d[k] = sum_q[k] + ioc_pkg::SUM_W'($signed(item.axes[k]));
						end
					end
					if (idx_q >= LAST_SUM) begin
						active_d = 1'b0;
						idx_d    = '0;
						done     = 1'b1;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			ioc_pkg::OP_START: begin
				sum_d    = '0;
				idx_d    = '0;
				active_d = 1'b1;
			end
			default: begin
				// load is handled at the bias register, code 3 does nothing
			end
		endcase
		res.calibrating = active_d;
		res.calib_done  = done;
	end

	ioc_mean_div u_div (
		.clk         (clk),
		.capture     (state_q == ST_MUL),
		.sums        (sum_q),
		.accel_range (accel_range),
		.bias_new    (bias_new)
	);

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q   <= '0;
			sum_q    <= '0;
			idx_q    <= '0;
			active_q <= 1'b0;
			state_q  <= ST_IDLE;
		end else begin
			if (adv) begin
				sum_q    <= sum_d;
				idx_q    <= idx_d;
				active_q <= active_d;
				if (item.op == ioc_pkg::OP_LOAD) begin
					bias_q <= item.axes;
				end
			end
			if (state_q == ST_FIN) begin
				bias_q <= bias_new;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (adv && done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_FIN;
				ST_FIN:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// no item may pass while the new biases are being worked out
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !adv)
		else $error("item advanced during bias update");

	a_done_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && done) |=> (state_q == ST_MUL))
		else $error("completed run did not start bias update");

	a_no_run_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !active_q)
		else $error("calibration run open during bias update");

	a_fin_follows_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_FIN))
		else $error("bias update sequence broken");

endmodule

@@ hdl/imu_offset_calibrate_correct.sv @@
// an accepted item is registered in the input stage and then in the result register
// throughput: one item per cycle when the result register is free and no bias update runs,
// set by the single correction/accumulate stage; after the sample that completes a run the
// stage holds while the six means go through the reciprocal multiplier and clamp
// reset: asynchronous active low, clears biases, sums, run state, range and both stages
module imu_offset_calibrate_correct (
	input logic        clk,
	input logic        arst_n,
	ioc_smp_if.sink    smp,
	ioc_res_if.source  res,
	ioc_cfg_if.sink    cfg
);

	// input stage
	logic                          valid_s1;
	ioc_pkg::item_t                item_s1;

	// result register
	logic                          out_valid_q;
	ioc_pkg::result_t              out_q;

	logic [ioc_pkg::RANGE_W-1:0]   accel_range_q;

	ioc_pkg::result_t              core_res;
	logic                          core_busy;
	logic                          slot_free;
	logic                          adv;

	// the result register frees up in the same cycle its transfer completes
	assign slot_free = !out_valid_q || res.ready;
	// stage 1 item is worked on when there is room and no bias update runs
	assign adv       = valid_s1 && slot_free && !core_busy;
	assign smp.ready = !valid_s1 || adv;

	// range register, written at any time the host wants
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_range_q <= '0;
		end else if (cfg.valid) begin
			accel_range_q <= cfg.data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (smp.ready) begin
			valid_s1 <= smp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (smp.valid && smp.ready) begin
			item_s1.op                   <= ioc_pkg::op_t'(smp.op);
			item_s1.axes[ioc_pkg::AX_I]  <= smp.accel_x;
			item_s1.axes[ioc_pkg::AY_I]  <= smp.accel_y;
			item_s1.axes[ioc_pkg::AZ_I]  <= smp.accel_z;
			item_s1.axes[ioc_pkg::GX_I]  <= smp.gyro_x;
			item_s1.axes[ioc_pkg::GY_I]  <= smp.gyro_y;
			item_s1.axes[ioc_pkg::GZ_I]  <= smp.gyro_z;
		end
	end

	// bias subtract, accumulate and run control
	ioc_calib_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.item        (item_s1),
		.accel_range (accel_range_q),
		.res         (core_res),
		.busy        (core_busy)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= core_res;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.corr_accel_x = out_q.corr[ioc_pkg::AX_I];
	assign res.corr_accel_y = out_q.corr[ioc_pkg::AY_I];
	assign res.corr_accel_z = out_q.corr[ioc_pkg::AZ_I];
	assign res.corr_gyro_x  = out_q.corr[ioc_pkg::GX_I];
	assign res.corr_gyro_y  = out_q.corr[ioc_pkg::GY_I];
	assign res.corr_gyro_z  = out_q.corr[ioc_pkg::GZ_I];
	assign res.calibrating  = out_q.calibrating;
	assign res.calib_done   = out_q.calib_done;

endmodule

@@ sim/tb_imu_offset_calibrate_correct.sv @@
module tb_imu_offset_calibrate_correct;
	import ioc_pkg::*;

	// op code the block must ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int CYCLE_LIMIT   = 200000;
	// cycles of quiet before a range write and before the final verdict
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 80;
	localparam int RUN_LEN       = DISCARD + AVG_COUNT;

	typedef struct packed {
		logic [1:0] op;
		axes_t      axes;
	} imu_item_t;

	logic clk = 1'b0;
	logic arst_n;

	ioc_smp_if smp ();
	ioc_res_if res ();
	ioc_cfg_if cfg ();

	imu_offset_calibrate_correct DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp),
		.res    (res),
		.cfg    (cfg)
	);

	always #5 clk = ~clk;

	// items waiting for the driver, and corrected samples still to come back
	imu_item_t imu_item_q[$];
	result_t   corrected_q[$];

	// own copy of the block state: biases, run sums, run position, range
	logic signed [AXIS_W-1:0] bias_est[NAXES];
	logic signed [SUM_W-1:0]  sum_acc[NAXES];
	logic [IDX_W-1:0]         run_idx;
	logic                     run_open;
	logic [RANGE_W-1:0]       accel_range_est;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatch_cnt   = 0;
	int result_cnt     = 0;
	int cycle_cnt;

	// long receiver hold-off, requested by toggling hold_req
	int   hold_left = 0;
	logic hold_req  = 1'b0;
	logic hold_ack  = 1'b0;

	// per-axis center values of the calibration run being generated
	int run_base[NAXES];

	string axis_name[NAXES] = '{"corr_accel_x", "corr_accel_y", "corr_accel_z",
		"corr_gyro_x", "corr_gyro_y", "corr_gyro_z"};

	imu_item_t on_bus;
	result_t   predicted;
	result_t   seen;
	result_t   want;

	int range_seq[4]   = '{3, 0, 2, 1};
	int send_idle_seq[4] = '{0, 53, 0, 13};
	int recv_stall_seq[4] = '{0, 0, 53, 13};

	function automatic logic signed [AXIS_W-1:0] clamp_axis(input int v);
		if (v > 32767) begin
			return AXIS_W'(32767);
		end else if (v < -32768) begin
			return AXIS_W'(-32768);
		end
		return AXIS_W'(v);
	endfunction

	// correction, run accumulation and bias update for one accepted item
	function automatic void predict_corrected(input imu_item_t it, output result_t r);
		int diff;
		int mean;
		r = '0;
		case (it.op)
			OP_SAMPLE: begin
				for (int k = 0; k < NAXES; k++) begin
					diff = int'($signed(it.axes[k])) - int'(bias_est[k]);
					r.corr[k] = clamp_axis(diff);
				end
				if (run_open) begin
					// skipped samples still advance the run position
					if (run_idx >= DISCARD) begin
						for (int k = 0; k < NAXES; k++) begin
							sum_acc[k] = sum_acc[k] + $signed(it.axes[k]);
						end
					end
					if (run_idx >= RUN_LEN - 1) begin
						// truncating mean; z loses one g at the current range
						for (int k = 0; k < NAXES; k++) begin
							mean = int'(sum_acc[k]) / AVG_COUNT;
							bias_est[k] = clamp_axis(mean);
						end
						bias_est[AZ_I] = clamp_axis(int'(bias_est[AZ_I]) -
							(16384 >> accel_range_est));
						run_open = 1'b0;
						run_idx = '0;
						r.calib_done = 1'b1;
					end else begin
						run_idx = run_idx + 1'b1;
					end
				end
			end
			OP_START: begin
				for (int k = 0; k < NAXES; k++) begin
					sum_acc[k] = '0;
				end
				run_idx = '0;
				run_open = 1'b1;
			end
			OP_LOAD: begin
				for (int k = 0; k < NAXES; k++) begin
					bias_est[k] = it.axes[k];
				end
			end
			default: begin
			end
		endcase
		r.calibrating = run_open;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		mismatch_cnt++;
		$display("result %0d: %s got %0d, expected %0d", result_cnt, what, got, exp_val);
	endtask

	task automatic push_item(input logic [1:0] op, input axes_t v);
		imu_item_t it;
		it.op = op;
		it.axes = v;
		imu_item_q.push_back(it);
	endtask

	function automatic axes_t make_axes(input logic [AXIS_W-1:0] ax, ay, az, gx, gy, gz);
		axes_t v;
		v[AX_I] = ax;
		v[AY_I] = ay;
		v[AZ_I] = az;
		v[GX_I] = gx;
		v[GY_I] = gy;
		v[GZ_I] = gz;
		return v;
	endfunction

	function automatic axes_t random_axes();
		axes_t v;
		for (int k = 0; k < NAXES; k++) begin
			v[k] = AXIS_W'($urandom);
		end
		return v;
	endfunction

	// one axis value of a calibration run, shaped by the run profile
	function automatic logic [AXIS_W-1:0] run_sample(input int profile, input int k);
		case (profile)
			// spread over the full range, sums of either sign
			0: return AXIS_W'($urandom);
			// sensor-like: steady offset with a little noise
			1: return AXIS_W'(run_base[k] + int'($urandom_range(510)) - 255);
			// rails: z pinned low so the g removal clamps
			2: begin
				if (k == AZ_I || $urandom_range(1) == 0) begin
					return AXIS_MIN;
				end
				return AXIS_MAX;
			end
			// near zero, fractional means truncate toward zero
			default: return AXIS_W'(run_base[k] + int'($urandom_range(6)) - 3);
		endcase
	endfunction

	// wait until every item has gone through and every result has come back
	task automatic wait_drained();
		@(negedge clk);
		while (imu_item_q.size() != 0 || smp.valid || corrected_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		for (int k = 0; k < NAXES; k++) begin
			bias_est[k] = '0;
			sum_acc[k] = '0;
		end
		run_idx = '0;
		run_open = 1'b0;
		accel_range_est = '0;
	end

	// driver: puts queued items on the sample channel, predicts on each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp.valid <= 1'b0;
		end else begin
			if (smp.valid && smp.ready) begin
				predict_corrected(on_bus, predicted);
				corrected_q.push_back(predicted);
			end
			// a held item stays on the bus until it transfers
			if (!smp.valid || smp.ready) begin
				if (imu_item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_bus = imu_item_q.pop_front();
					smp.valid <= 1'b1;
					smp.op <= on_bus.op;
					smp.accel_x <= on_bus.axes[AX_I];
					smp.accel_y <= on_bus.axes[AY_I];
					smp.accel_z <= on_bus.axes[AZ_I];
					smp.gyro_x <= on_bus.axes[GX_I];
					smp.gyro_y <= on_bus.axes[GY_I];
					smp.gyro_z <= on_bus.axes[GZ_I];
				end else begin
					smp.valid <= 1'b0;
				end
			end
		end
	end

	// long hold-off counter for the receiver
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			hold_left <= HOLD_CYCLES;
			hold_ack <= hold_req;
		end
	end

	// monitor: checks each result transfer against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				result_cnt++;
				seen.corr[AX_I] = res.corr_accel_x;
				seen.corr[AY_I] = res.corr_accel_y;
				seen.corr[AZ_I] = res.corr_accel_z;
				seen.corr[GX_I] = res.corr_gyro_x;
				seen.corr[GY_I] = res.corr_gyro_y;
				seen.corr[GZ_I] = res.corr_gyro_z;
				seen.calibrating = res.calibrating;
				seen.calib_done = res.calib_done;
				if (corrected_q.size() == 0) begin
					report_mismatch("result with nothing pending, calib_done", seen.calib_done, 0);
				end else begin
					want = corrected_q.pop_front();
					for (int k = 0; k < NAXES; k++) begin
						if (seen.corr[k] !== want.corr[k]) begin
							report_mismatch(axis_name[k], $signed(seen.corr[k]),
								$signed(want.corr[k]));
						end
					end
					if (seen.calibrating !== want.calibrating) begin
						report_mismatch("calibrating", seen.calibrating, want.calibrating);
					end
					if (seen.calib_done !== want.calib_done) begin
						report_mismatch("calib_done", seen.calib_done, want.calib_done);
					end
				end
			end
			res.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int pick;
		int abort_len;
		axes_t v;

		smp.valid = 1'b0;
		smp.op = OP_SAMPLE;
		smp.accel_x = '0;
		smp.accel_y = '0;
		smp.accel_z = '0;
		smp.gyro_x = '0;
		smp.gyro_y = '0;
		smp.gyro_z = '0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: zero biases, rails, loads, ignored op, run start and restart
		push_item(OP_SAMPLE, make_axes(0, 0, 0, 0, 0, 0));
		push_item(OP_SAMPLE, make_axes(AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX,
			AXIS_MAX));
		push_item(OP_SAMPLE, make_axes(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN,
			AXIS_MIN));
		push_item(OP_LOAD, make_axes(AXIS_MAX, AXIS_MIN, 16'h0001, 16'hFFFF, 16'h5555,
			16'hAAAA));
		// subtraction clamps at both rails
		push_item(OP_SAMPLE, make_axes(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN,
			AXIS_MIN));
		push_item(OP_SAMPLE, make_axes(AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX,
			AXIS_MAX));
		push_item(OP_UNUSED, make_axes(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF));
		push_item(OP_LOAD, make_axes(AXIS_MIN, AXIS_MAX, AXIS_MIN, AXIS_MAX, AXIS_MIN,
			AXIS_MAX));
		push_item(OP_SAMPLE, make_axes(AXIS_MAX, AXIS_MIN, AXIS_MAX, AXIS_MIN, AXIS_MAX,
			AXIS_MIN));
		push_item(OP_SAMPLE, random_axes());
		// run open: discarded samples, load and ignored op inside the run
		push_item(OP_START, random_axes());
		push_item(OP_SAMPLE, random_axes());
		push_item(OP_UNUSED, random_axes());
		push_item(OP_LOAD, make_axes(16'h1234, 16'hEDCC, 16'h4000, 16'hC000, 16'h0100,
			16'hFF00));
		push_item(OP_SAMPLE, random_axes());
		// restart while open
		push_item(OP_START, make_axes(0, 0, 0, 0, 0, 0));
		push_item(OP_SAMPLE, make_axes(0, 0, 0, 0, 0, 0));
		push_item(OP_LOAD, make_axes(0, 0, 0, 0, 0, 0));
		push_item(OP_SAMPLE, random_axes());
		push_item(OP_UNUSED, make_axes(0, 0, 0, 0, 0, 0));

		for (int p = 0; p < 4; p++) begin
			wait_drained();
			// range write with nothing in flight
			cfg.valid <= 1'b1;
			cfg.data <= RANGE_W'(range_seq[p]);
			@(posedge clk);
			while (!cfg.ready) begin
				@(posedge clk);
			end
			accel_range_est = RANGE_W'(range_seq[p]);
			cfg.valid <= 1'b0;
			@(negedge clk);
			send_idle_pct = send_idle_seq[p];
			recv_stall_pct = recv_stall_seq[p];

			// noise: any op, any content
			for (int i = 0; i < 30; i++) begin
				pick = $urandom_range(99);
				if (pick < 55) begin
					push_item(OP_SAMPLE, random_axes());
				end else if (pick < 65) begin
					push_item(OP_START, random_axes());
				end else if (pick < 85) begin
					push_item(OP_LOAD, random_axes());
				end else begin
					push_item(OP_UNUSED, random_axes());
				end
			end

			// run cut short by a new start, sometimes past the discard window
			abort_len = $urandom_range(120, 5);
			push_item(OP_START, random_axes());
			for (int i = 0; i < abort_len; i++) begin
				push_item(OP_SAMPLE, random_axes());
			end

			// one full run, with both sides idling, loads and ignored ops mixed in
			if (p == 3) begin
				for (int k = 0; k < NAXES; k++) begin
					run_base[k] = int'($urandom_range(40000)) - 20000;
				end
				// z sits near the low rail so the g removal clamps
				run_base[AZ_I] = -32000;
				push_item(OP_START, random_axes());
				for (int i = 0; i < RUN_LEN; i++) begin
					pick = $urandom_range(199);
					if (pick == 0) begin
						push_item(OP_LOAD, random_axes());
					end else if (pick == 1) begin
						push_item(OP_UNUSED, random_axes());
					end
					for (int k = 0; k < NAXES; k++) begin
						v[k] = run_sample(1, k);
					end
					push_item(OP_SAMPLE, v);
				end
				// samples corrected with the fresh biases
				for (int i = 0; i < 30; i++) begin
					push_item(OP_SAMPLE, random_axes());
				end
			end

			// receiver backs off while the driver keeps offering
			if (p % 2 == 1) begin
				hold_req = ~hold_req;
			end
		end

		wait_drained();
		if (mismatch_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ imu_offset_calibrate_correct.f @@
hdl/ioc_pkg.sv
hdl/ioc_if.sv
hdl/ioc_mean_div.sv
hdl/ioc_calib_core.sv
hdl/imu_offset_calibrate_correct.sv
sim/tb_imu_offset_calibrate_correct.sv
